/* rtl/core/bb5_pkg.sv */
// ----------------------------------------------------------------------------
// bb5_pkg
// Shared types, constants and helper functions of the 5x5 RGB box blur.
// ----------------------------------------------------------------------------
package bb5_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int KERNEL      = 5;
   localparam int LINES       = KERNEL - 1;
   localparam int PIX_W       = 24;
   localparam int LANE_SUM_W  = 11;
   localparam int SUM_W       = 13;
   localparam int RECIP_W     = 20;
   localparam int RECIP_SHIFT = 19;
   localparam int CNT_W       = 5;

   localparam logic [11:0] WIDTH_RESET  = 12'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [7:0] blue_in;
      logic [7:0] green_in;
      logic [7:0] red_in;
      logic       flush;
   } pixel_in_type;

   typedef struct packed {
      logic [7:0] blue_out;
      logic [7:0] green_out;
      logic [7:0] red_out;
      logic       frame_last;
   } pixel_out_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      logic              last;
      logic [KERNEL-1:0] col_mask;
      logic [KERNEL-1:0] row_mask;
   } win_ctl_type;

   typedef struct packed {
      logic [LANE_SUM_W-1:0] blue;
      logic [LANE_SUM_W-1:0] green;
      logic [LANE_SUM_W-1:0] red;
   } lane_sum_type;

   typedef struct packed {
      logic [SUM_W-1:0]   blue;
      logic [SUM_W-1:0]   green;
      logic [SUM_W-1:0]   red;
      logic [RECIP_W-1:0] recip;
      logic               last;
   } merge_type;

   function automatic logic [2:0] count_bits(input logic [KERNEL-1:0] mask);
      logic [2:0] n;
      n = '0;
      for (int i = 0; i < KERNEL; i++) begin
         n = n + {2'b00, mask[i]};
      end
      return n;
   endfunction

   // Rounded-up reciprocal of the neighbour count, scaled by two to the nineteenth.
   function automatic logic [RECIP_W-1:0] recip_lookup(input logic [CNT_W-1:0] cnt);
      logic [RECIP_W-1:0] r;
      unique case (cnt)
         5'd2:    r = 20'd262144;
         5'd3:    r = 20'd174763;
         5'd4:    r = 20'd131072;
         5'd5:    r = 20'd104858;
         5'd6:    r = 20'd87382;
         5'd7:    r = 20'd74899;
         5'd8:    r = 20'd65536;
         5'd9:    r = 20'd58255;
         5'd10:   r = 20'd52429;
         5'd11:   r = 20'd47663;
         5'd12:   r = 20'd43691;
         5'd13:   r = 20'd40330;
         5'd14:   r = 20'd37450;
         5'd15:   r = 20'd34953;
         5'd16:   r = 20'd32768;
         5'd17:   r = 20'd30841;
         5'd18:   r = 20'd29128;
         5'd19:   r = 20'd27595;
         5'd20:   r = 20'd26215;
         5'd21:   r = 20'd24967;
         5'd22:   r = 20'd23832;
         5'd23:   r = 20'd22796;
         5'd24:   r = 20'd21846;
         5'd25:   r = 20'd20972;
         default: r = 20'd524288;
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/bb5_ram.sv */
// ----------------------------------------------------------------------------
// bb5_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bb5_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/bb5_lane.sv */
// ----------------------------------------------------------------------------
// bb5_lane
// Sums one window column per channel over the rows that lie inside the frame.
// ----------------------------------------------------------------------------
module bb5_lane (
   input  logic                             clock,
   input  logic                             enable,
   input  bb5_pkg::rgb_type                 column [bb5_pkg::KERNEL],
   input  logic [bb5_pkg::KERNEL-1:0]       row_mask,
   input  logic                             col_en,
   output bb5_pkg::lane_sum_type            sum
);
   import bb5_pkg::*;

   lane_sum_type sum_in;
   lane_sum_type sum_ff;

   always_comb begin
      sum_in = '0;
      for (int j = 0; j < KERNEL; j++) begin
         if (row_mask[j] && col_en) begin
            sum_in.blue  = sum_in.blue  + {3'b000, column[j].blue};
            sum_in.green = sum_in.green + {3'b000, column[j].green};
            sum_in.red   = sum_in.red   + {3'b000, column[j].red};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

/* rtl/core/bb5_merge.sv */
// ----------------------------------------------------------------------------
// bb5_merge
// Combines the column sums of all lanes and looks up the count reciprocal.
// ----------------------------------------------------------------------------
module bb5_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  bb5_pkg::win_ctl_type  in_ctl,
   input  bb5_pkg::lane_sum_type lane [bb5_pkg::KERNEL],
   output logic                  out_valid,
   output bb5_pkg::merge_type    out_data
);
   import bb5_pkg::*;

   logic       valid_ff;
   merge_type  data_in;
   merge_type  data_ff;
   logic [5:0] cnt_full;

   always_comb begin
      data_in = '0;
      for (int k = 0; k < KERNEL; k++) begin
         data_in.blue  = data_in.blue  + {2'b00, lane[k].blue};
         data_in.green = data_in.green + {2'b00, lane[k].green};
         data_in.red   = data_in.red   + {2'b00, lane[k].red};
      end
      cnt_full      = count_bits(in_ctl.col_mask) * count_bits(in_ctl.row_mask);
      data_in.recip = recip_lookup(cnt_full[CNT_W-1:0]);
      data_in.last  = in_ctl.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/core/box_blur_5x5_rgb.sv */
// ----------------------------------------------------------------------------
// box_blur_5x5_rgb
// Streaming 5x5 mean blur of a raster-order RGB frame with border clipping.
// Path: a result moves through the stage-1, window, lane-sum and merge registers
// into the output register; results trail the input by two rows plus two pixels.
// Throughput: one transaction per cycle while the output is not held off, set by the single line-store port pair.
// Reset: synchronous, active high; clears counters and valid flags and restores the frame size defaults.
// ----------------------------------------------------------------------------
module box_blur_5x5_rgb (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bb5_pkg::pixel_in_type  req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bb5_pkg::pixel_out_type rsp_data,
   input  logic                   csr_write,
   input  logic                   csr_index,
   input  logic [12:0]            csr_wdata
);
   import bb5_pkg::*;

   logic [11:0] width_ff;
   logic [12:0] height_ff;
   logic [11:0] w_eff;
   logic [12:0] h_eff;
   logic [12:0] lag;

   logic [13:0]       in_row_ff, in_row_in;
   logic [ADDR_W-1:0] in_col_ff, in_col_in;
   logic [12:0]       lag_cnt_ff, lag_cnt_in;
   logic [12:0]       out_row_ff, out_row_in;
   logic [ADDR_W-1:0] out_col_ff, out_col_in;

   logic        pipe_en, active, ignore, step, emit, last;
   rgb_type     pix;
   win_ctl_type ctl;

   logic              s1_valid_ff, s1_emit_ff, s1_hit_ff;
   rgb_type           s1_pix_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   win_ctl_type       s1_ctl_ff;

   logic              s2_valid_ff;
   win_ctl_type       s2_ctl_ff;
   logic              s3_valid_ff;
   win_ctl_type       s3_ctl_ff;

   logic [LINES*PIX_W-1:0] ram_rd, ram_wr, last_wdata_ff, line_src;
   rgb_type                col [KERNEL];
   rgb_type                window_ff [KERNEL][KERNEL];

   lane_sum_type lane_sum [KERNEL];
   logic         m_valid;
   merge_type    m_data;

   logic                 rsp_valid_ff;
   pixel_out_type        rsp_data_in, rsp_data_ff;
   logic [32:0]          prod_b, prod_g, prod_r;

   assign w_eff = (width_ff == 12'd0) ? 12'd1 :
                  (width_ff > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : width_ff;
   assign h_eff = (height_ff == 13'd0) ? 13'd1 : height_ff;
   assign lag   = {w_eff, 1'b0} + 13'd2;

   assign pipe_en   = !rsp_valid_ff || rsp_ready;
   assign req_ready = pipe_en;

   always_comb begin
      active = in_row_ff < {1'b0, h_eff};
      ignore = req_data.flush && active;
      step   = req_valid && pipe_en && !ignore;
      emit   = lag_cnt_ff == lag;
      last   = emit && (out_row_ff == h_eff - 13'd1)
                    && ({1'b0, out_col_ff} == w_eff - 12'd1);
      if (req_data.flush || !active) begin
         pix = '0;
      end else begin
         pix.red   = req_data.red_in;
         pix.green = req_data.green_in;
         pix.blue  = req_data.blue_in;
      end
      ctl.last        = last;
      ctl.col_mask[0] = out_col_ff >= ADDR_W'(2);
      ctl.col_mask[1] = out_col_ff >= ADDR_W'(1);
      ctl.col_mask[2] = 1'b1;
      ctl.col_mask[3] = ({1'b0, out_col_ff} + 12'd1) < w_eff;
      ctl.col_mask[4] = ({1'b0, out_col_ff} + 12'd2) < w_eff;
      ctl.row_mask[0] = out_row_ff >= 13'd2;
      ctl.row_mask[1] = out_row_ff >= 13'd1;
      ctl.row_mask[2] = 1'b1;
      ctl.row_mask[3] = ({1'b0, out_row_ff} + 14'd1) < {1'b0, h_eff};
      ctl.row_mask[4] = ({1'b0, out_row_ff} + 14'd2) < {1'b0, h_eff};
   end

   always_comb begin
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      lag_cnt_in = lag_cnt_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (csr_write) begin
         in_row_in  = '0;
         in_col_in  = '0;
         lag_cnt_in = '0;
         out_row_in = '0;
         out_col_in = '0;
      end else if (step) begin
         if (last) begin
            in_row_in  = '0;
            in_col_in  = '0;
            lag_cnt_in = '0;
            out_row_in = '0;
            out_col_in = '0;
         end else begin
            if (({1'b0, in_col_ff} + 12'd1) >= w_eff) begin
               in_col_in = '0;
               in_row_in = in_row_ff + 14'd1;
            end else begin
               in_col_in = in_col_ff + ADDR_W'(1);
            end
            if (emit) begin
               if (({1'b0, out_col_ff} + 12'd1) >= w_eff) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + 13'd1;
               end else begin
                  out_col_in = out_col_ff + ADDR_W'(1);
               end
            end else begin
               lag_cnt_in = lag_cnt_ff + 13'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         lag_cnt_ff <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[11:0];
               CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
               default:          width_ff  <= width_ff;
            endcase
         end
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         lag_cnt_ff <= lag_cnt_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
      end
   end

   bb5_ram #(
      .WIDTH (LINES * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (pipe_en && s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (ram_wr),
      .rd_en   (step),
      .rd_addr (in_col_ff),
      .rd_data (ram_rd)
   );

   always_comb begin
      line_src = s1_hit_ff ? last_wdata_ff : ram_rd;
      for (int j = 0; j < LINES; j++) begin
         col[j] = line_src[j*PIX_W +: PIX_W];
      end
      col[LINES] = s1_pix_ff;
      for (int j = 0; j < LINES; j++) begin
         ram_wr[j*PIX_W +: PIX_W] = col[j+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= step;
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      if (pipe_en) begin
         s1_pix_ff  <= pix;
         s1_addr_ff <= in_col_ff;
         s1_hit_ff  <= s1_valid_ff && (s1_addr_ff == in_col_ff);
         s1_emit_ff <= emit;
         s1_ctl_ff  <= ctl;
         s2_ctl_ff  <= s1_ctl_ff;
         s3_ctl_ff  <= s2_ctl_ff;
      end
      if (pipe_en && s1_valid_ff) begin
         last_wdata_ff <= ram_wr;
         for (int k = 0; k < KERNEL - 1; k++) begin
            window_ff[k] <= window_ff[k+1];
         end
         window_ff[KERNEL-1] <= col;
      end
   end

   for (genvar k = 0; k < KERNEL; k++) begin : g_lane
      bb5_lane u_lane (
         .clock    (clock),
         .enable   (pipe_en),
         .column   (window_ff[k]),
         .row_mask (s2_ctl_ff.row_mask),
         .col_en   (s2_ctl_ff.col_mask[k]),
         .sum      (lane_sum[k])
      );
   end

   bb5_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_en),
      .in_valid  (s3_valid_ff),
      .in_ctl    (s3_ctl_ff),
      .lane      (lane_sum),
      .out_valid (m_valid),
      .out_data  (m_data)
   );

   always_comb begin
      prod_b = {20'd0, m_data.blue}  * {13'd0, m_data.recip};
      prod_g = {20'd0, m_data.green} * {13'd0, m_data.recip};
      prod_r = {20'd0, m_data.red}   * {13'd0, m_data.recip};
      rsp_data_in.blue_out   = prod_b[RECIP_SHIFT +: 8];
      rsp_data_in.green_out  = prod_g[RECIP_SHIFT +: 8];
      rsp_data_in.red_out    = prod_r[RECIP_SHIFT +: 8];
      rsp_data_in.frame_last = m_data.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= m_valid;
      end
      if (pipe_en && m_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/box_blur_5x5_rgb_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_5x5_rgb_tb
// Self-checking bench for the streaming 5x5 RGB mean blur. Whole frames of
// random and extreme pixels are sent through the block at several frame sizes,
// including the clamped width and height settings, and every result is checked
// against a behavioural blur kept in this bench. Both handshake sides idle at
// random, and one phase holds the output off long enough to stall the input.
// ----------------------------------------------------------------------------
module box_blur_5x5_rgb_tb;
   import bb5_pkg::*;

   localparam int IDLE_LIMIT = 5000;
   localparam int LONG_HOLD  = 200;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   pixel_in_type  req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   pixel_out_type rsp_data;
   logic          csr_write = 1'b0;
   logic          csr_index = CSR_FRAME_WIDTH;
   logic [12:0]   csr_wdata = '0;

   box_blur_5x5_rgb dut (.*);

   always #5 clock = ~clock;

   // Blur state kept by the bench.
   logic [23:0] line_mem [LINES][MAX_WIDTH];
   logic [23:0] win [KERNEL][KERNEL];
   int unsigned pos_row, pos_col;
   logic [11:0] width_reg;
   logic [12:0] height_reg;
   bit          frame_done;
   bit          last_ignored;

   pixel_out_type blur_queue[$];
   int errors, results_checked, pixels_sent, frames_done;
   bit no_idle;
   int hold_seq, hold_seen, stall, idle_cycles;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
               results_checked);
      errors++;
   endtask

   task automatic clear_blur_state();
      for (int j = 0; j < LINES; j++)
         for (int i = 0; i < MAX_WIDTH; i++) line_mem[j][i] = '0;
      for (int k = 0; k < KERNEL; k++)
         for (int j = 0; j < KERNEL; j++) win[k][j] = '0;
      pos_row = 0;
      pos_col = 0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
   endtask

   task automatic predict_blur(input pixel_in_type item);
      int unsigned w, h, total, lag, c, p, q, cnt, sb, sg, sr;
      int cr, cc, x, y;
      bit fl, last;
      logic [23:0] pix, v;
      logic [23:0] column [KERNEL];
      pixel_out_type res;
      w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
      h = (height_reg == 0) ? 1 : height_reg;
      total = w * h;
      lag = 2 * w + 2;
      c = (pos_col < w) ? pos_col : w - 1;
      p = pos_row * w + c;
      fl = item.flush;
      last_ignored = 1'b0;
      if (fl && p < total) begin
         last_ignored = 1'b1;
         return;
      end
      if (p >= total) fl = 1'b1;
      pix = fl ? 24'd0 : {item.red_in, item.green_in, item.blue_in};
      for (int j = 0; j < LINES; j++) column[j] = line_mem[j][c];
      column[LINES] = pix;
      for (int j = 0; j < LINES - 1; j++) line_mem[j][c] = column[j + 1];
      line_mem[LINES - 1][c] = pix;
      for (int k = 0; k < KERNEL - 1; k++)
         for (int j = 0; j < KERNEL; j++) win[k][j] = win[k + 1][j];
      for (int j = 0; j < KERNEL; j++) win[KERNEL - 1][j] = column[j];
      last = 1'b0;
      if (p >= lag && p - lag < total) begin
         q = p - lag;
         cr = q / w;
         cc = q % w;
         sb = 0; sg = 0; sr = 0; cnt = 0;
         for (int dx = -2; dx <= 2; dx++) begin
            x = cc + dx;
            if (x < 0 || x >= int'(w)) continue;
            for (int dy = -2; dy <= 2; dy++) begin
               y = cr + dy;
               if (y < 0 || y >= int'(h)) continue;
               v = win[dx + 2][dy + 2];
               sb += v[7:0];
               sg += v[15:8];
               sr += v[23:16];
               cnt++;
            end
         end
         if (cnt == 0) cnt = 1;
         last = (q == total - 1);
         res.blue_out = 8'(sb / cnt);
         res.green_out = 8'(sg / cnt);
         res.red_out = 8'(sr / cnt);
         res.frame_last = last;
         blur_queue.push_back(res);
      end
      if (last) begin
         pos_row = 0;
         pos_col = 0;
         frame_done = 1'b1;
      end else begin
         pos_col = c + 1;
         if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
         end
      end
   endtask

   function automatic int gap_len();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   task automatic send_pixel(input pixel_in_type item);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      predict_blur(item);
      if (!last_ignored) pixels_sent++;
   endtask

   function automatic pixel_in_type random_pixel(input bit fl);
      pixel_in_type it;
      it.blue_in = 8'($urandom);
      it.green_in = 8'($urandom);
      it.red_in = 8'($urandom);
      it.flush = fl;
      return it;
   endfunction

   task automatic settle();
      req_valid <= 1'b0;
      while (blur_queue.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [12:0] value);
      settle();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) width_reg = value[11:0];
      else height_reg = value;
      pos_row = 0;
      pos_col = 0;
   endtask

   // Sends one frame and drains it; stray flushes and drain pixels at the given odds.
   task automatic run_frame(input int flush_pct, input int drain_pix_pct);
      int unsigned w, h;
      w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
      h = (height_reg == 0) ? 1 : height_reg;
      frame_done = 1'b0;
      for (int unsigned i = 0; i < w * h; i++) begin
         if ($urandom_range(0, 99) < flush_pct) send_pixel(random_pixel(1'b1));
         send_pixel(random_pixel(1'b0));
      end
      while (!frame_done)
         send_pixel(random_pixel($urandom_range(0, 99) >= drain_pix_pct));
      frames_done++;
   endtask

   task automatic set_size(input logic [12:0] w, input logic [12:0] h);
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
   endtask

   task automatic test_extremes();
      pixel_in_type it;
      set_size(13'd4, 13'd3);
      frame_done = 1'b0;
      for (int i = 0; i < 12; i++) begin
         it.blue_in = (i % 2) ? 8'hFF : 8'h00;
         it.green_in = (i % 3) ? 8'hFF : 8'h00;
         it.red_in = (i < 6) ? 8'hFF : 8'h00;
         it.flush = 1'b0;
         send_pixel(it);
         if (i == 5) send_pixel(random_pixel(1'b1));
      end
      send_pixel(random_pixel(1'b0));
      while (!frame_done) send_pixel(random_pixel(1'b1));
      frames_done++;
   endtask

   task automatic test_clamped_sizes();
      set_size(13'd0, 13'd0);
      run_frame(10, 30);
      set_size(13'd1, 13'd4);
      run_frame(10, 30);
      set_size(13'd7, 13'd1);
      run_frame(10, 30);
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      set_size(13'd5, 13'd5);
      run_frame(0, 0);
      run_frame(0, 0);
      no_idle = 1'b0;
      run_frame(15, 20);
   endtask

   task automatic test_output_stall();
      set_size(13'd16, 13'd4);
      hold_seq++;
      no_idle = 1'b1;
      run_frame(0, 0);
      no_idle = 1'b0;
   endtask

   task automatic test_random_frames();
      int start;
      start = pixels_sent;
      while (pixels_sent - start < 1080) begin
         if ($urandom_range(0, 4) == 0)
            write_csr(CSR_FRAME_WIDTH, 13'($urandom_range(20, 40)));
         else
            write_csr(CSR_FRAME_WIDTH, 13'($urandom_range(1, 12)));
         write_csr(CSR_FRAME_HEIGHT, 13'($urandom_range(1, 8)));
         no_idle = ($urandom_range(0, 3) == 0);
         run_frame($urandom_range(0, 10), $urandom_range(0, 30));
      end
      no_idle = 1'b0;
   endtask

   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         stall <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (stall > 0) begin
         stall <= stall - 1;
         rsp_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
         stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pixel_out_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (blur_queue.size() == 0) begin
            $display("unexpected result transaction (result %0d)", results_checked);
            errors++;
         end else begin
            want = blur_queue.pop_front();
            if (rsp_data.blue_out !== want.blue_out)
               report("blue_out", rsp_data.blue_out, want.blue_out);
            if (rsp_data.green_out !== want.green_out)
               report("green_out", rsp_data.green_out, want.green_out);
            if (rsp_data.red_out !== want.red_out)
               report("red_out", rsp_data.red_out, want.red_out);
            if (rsp_data.frame_last !== want.frame_last)
               report("frame_last", rsp_data.frame_last, want.frame_last);
         end
         results_checked++;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clear_blur_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_clamped_sizes();
      test_back_to_back();
      test_output_stall();
      test_random_frames();
      settle();
      repeat (20) @(posedge clock);
      $display("%0d frames, %0d pixel transactions, %0d results checked, %0d mismatches",
               frames_done, pixels_sent, results_checked, errors);
      $display("sizes from 1x1 up to 40 pixels wide and 8 rows high, stalls on both sides");
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/bb5_pkg.sv
rtl/core/bb5_ram.sv
rtl/core/bb5_lane.sv
rtl/core/bb5_merge.sv
rtl/core/box_blur_5x5_rgb.sv
tb/box_blur_5x5_rgb_tb.sv
